@@ hdl/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// mct_pkg
// shared constants, payload types and sequencer states of the multiset
// counting table
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int DIST_W      = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_POPULAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [KEY_WIDTH-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] occurrences;
    logic [DIST_W-1:0]      distinct_keys;
    logic [KEY_WIDTH-1:0]   popular_key;
    logic                   bag_empty;
    logic                   table_full;
  } out_item_t;

  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic upd_en;
    logic load_out;
  } ctrl_t;

endpackage

@@ hdl/multiset_counting_table_unit.sv @@
// ----------------------------------------------------------------------------
// multiset_counting_table_unit
// bounded multiset of keys with occurrence counts; one entry is visited per
// cycle by a single compare unit under a small sequencer
// ----------------------------------------------------------------------------
// flow: accept an input beat, scan all ENTRIES entries, update, then load the output register,
// which waits while an unread result is held; a new item is accepted only after that load
// the output register holds a result while the next item is being scanned
// reset: synchronous, active low; clears all entry valid bits, distinct count
// and the sequencer, no clearing pass is needed
module multiset_counting_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mct_pkg::out_item_t  out_data
);

  localparam logic [mct_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [mct_pkg::IDX_W-1:0] LAST_IDX = mct_pkg::IDX_W'(mct_pkg::ENTRIES - 1);

  mct_pkg::state_t state_r, state_nxt;
  mct_pkg::ctrl_t  ctrl;

  // entry storage
  logic [mct_pkg::ENTRIES-1:0]   valid_r;
  logic [mct_pkg::KEY_WIDTH-1:0] key_r   [mct_pkg::ENTRIES];
  logic [mct_pkg::COUNT_WIDTH-1:0] count_r [mct_pkg::ENTRIES];
  logic [mct_pkg::IDX_W-1:0]     age_r   [mct_pkg::ENTRIES];
  logic [mct_pkg::DIST_W-1:0]    distinct_r, distinct_nxt;

  // item under work
  mct_pkg::cmd_t                 cmd_r;
  logic [mct_pkg::KEY_WIDTH-1:0] item_key_r;
  logic [mct_pkg::IDX_W-1:0]     idx_r;

  // scan results
  logic                            hit_r;
  logic [mct_pkg::IDX_W-1:0]       hit_idx_r;
  logic [mct_pkg::COUNT_WIDTH-1:0] hit_cnt_r;
  logic [mct_pkg::IDX_W-1:0]       hit_age_r;
  logic                            free_r;
  logic [mct_pkg::IDX_W-1:0]       free_idx_r;
  logic                            best_r;
  logic [mct_pkg::COUNT_WIDTH-1:0] best_cnt_r;
  logic [mct_pkg::IDX_W-1:0]       best_age_r;
  logic [mct_pkg::KEY_WIDTH-1:0]   best_key_r;

  mct_pkg::out_item_t res_r, res_nxt;
  mct_pkg::out_item_t out_r;
  logic               out_valid_r;

  // current entry
  logic                            cur_valid;
  logic [mct_pkg::KEY_WIDTH-1:0]   cur_key;
  logic [mct_pkg::COUNT_WIDTH-1:0] cur_cnt;
  logic [mct_pkg::IDX_W-1:0]       cur_age;
  logic                            cur_match;
  logic                            cur_better;

  // update decisions
  logic                            add_hit, add_new, rem_hit, rem_zero;
  logic [mct_pkg::COUNT_WIDTH-1:0] new_cnt;

  assign cur_valid = valid_r[idx_r];
  assign cur_key   = key_r[idx_r];
  assign cur_cnt   = count_r[idx_r];
  assign cur_age   = age_r[idx_r];

  // shared compare unit: key equality for lookups, rank order for popular
  always_comb begin
    cur_match  = 1'b0;
    cur_better = 1'b0;
    if (cmd_r == mct_pkg::CMD_POPULAR) begin
      cur_better = cur_valid && (!best_r || (cur_cnt > best_cnt_r) ||
                   ((cur_cnt == best_cnt_r) && (cur_age < best_age_r)));
    end else begin
      cur_match = cur_valid && !hit_r && (cur_key == item_key_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mct_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mct_pkg::ST_SCAN;
      end
      mct_pkg::ST_SCAN: begin
        if (idx_r == LAST_IDX) state_nxt = mct_pkg::ST_UPDATE;
      end
      mct_pkg::ST_UPDATE: state_nxt = mct_pkg::ST_DONE;
      mct_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = mct_pkg::ST_IDLE;
      end
      default: state_nxt = mct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      mct_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
      mct_pkg::ST_SCAN:   ctrl.scan_en  = 1'b1;
      mct_pkg::ST_UPDATE: ctrl.upd_en   = 1'b1;
      mct_pkg::ST_DONE:   ctrl.load_out = !out_valid_r || out_ready;
      default:            ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mct_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // update decisions and result
  always_comb begin
    add_hit      = (cmd_r == mct_pkg::CMD_ADD) && hit_r;
    add_new      = (cmd_r == mct_pkg::CMD_ADD) && !hit_r && free_r;
    rem_hit      = (cmd_r == mct_pkg::CMD_REMOVE) && hit_r;
    new_cnt      = hit_cnt_r;
    if (add_hit && (hit_cnt_r != COUNT_MAX)) new_cnt = hit_cnt_r + 1'b1;
    if (rem_hit) new_cnt = hit_cnt_r - 1'b1;
    rem_zero     = rem_hit && (new_cnt == '0);
    distinct_nxt = distinct_r;
    if (add_new)  distinct_nxt = distinct_r + 1'b1;
    if (rem_zero) distinct_nxt = distinct_r - 1'b1;

    res_nxt               = '0;
    res_nxt.distinct_keys = distinct_nxt;
    case (cmd_r)
      mct_pkg::CMD_ADD: begin
        if (hit_r) begin
          res_nxt.occurrences = new_cnt;
        end else if (free_r) begin
          res_nxt.occurrences = mct_pkg::COUNT_WIDTH'(1);
        end else begin
          res_nxt.table_full = 1'b1;
        end
      end
      mct_pkg::CMD_REMOVE: begin
        if (hit_r) res_nxt.occurrences = new_cnt;
      end
      mct_pkg::CMD_COUNT: begin
        if (hit_r) res_nxt.occurrences = hit_cnt_r;
      end
      mct_pkg::CMD_POPULAR: begin
        if (best_r) begin
          res_nxt.occurrences = best_cnt_r;
          res_nxt.popular_key = best_key_r;
        end else begin
          res_nxt.bag_empty = 1'b1;
        end
      end
      default: res_nxt = '0;
    endcase
  end

  // item capture and scan
  always_ff @(posedge clk) begin
    if (ctrl.in_ready && in_valid) begin
      cmd_r      <= mct_pkg::cmd_t'(in_data.command);
      item_key_r <= in_data.key;
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_r     <= 1'b0;
    end else if (ctrl.scan_en) begin
      idx_r <= idx_r + 1'b1;
      if (cur_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx_r;
        hit_cnt_r <= cur_cnt;
        hit_age_r <= cur_age;
      end
      if (!cur_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (cur_better) begin
        best_r     <= 1'b1;
        best_cnt_r <= cur_cnt;
        best_age_r <= cur_age;
        best_key_r <= cur_key;
      end
    end
    if (ctrl.upd_en) res_r <= res_nxt;
  end

  // entry write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      distinct_r <= '0;
    end else if (ctrl.upd_en) begin
      distinct_r <= distinct_nxt;
      if (add_new)  valid_r[free_idx_r] <= 1'b1;
      if (rem_zero) valid_r[hit_idx_r]  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd_en) begin
      for (int i = 0; i < mct_pkg::ENTRIES; i++) begin
        if (add_new && valid_r[i]) age_r[i] <= age_r[i] + 1'b1;
        if (rem_zero && valid_r[i] && (age_r[i] > hit_age_r)) age_r[i] <= age_r[i] - 1'b1;
      end
      if (add_hit || rem_hit) count_r[hit_idx_r] <= new_cnt;
      if (add_new) begin
        key_r[free_idx_r]   <= item_key_r;
        count_r[free_idx_r] <= mct_pkg::COUNT_WIDTH'(1);
        age_r[free_idx_r]   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) out_r <= res_r;
  end

  // no input beat is taken while reset is held
  assign in_ready  = ctrl.in_ready && rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
